// File: rtl/assert_macros.svh
// Assertion macros shared by the trigger packet unpacker RTL.
// Clocked on clk, disabled while rst_n is low; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition holds at every edge out of reset.
`define TPU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent at one edge implies consequent at the next.
`define TPU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
// Antecedent implies consequent at the same edge.
`define TPU_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define TPU_ASSERT(lbl, expr, msg)
`define TPU_ASSERT_NEXT(lbl, pre, post, msg)
`define TPU_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

// File: rtl/tpu_pkg.sv
// Package for the trigger packet unpacker: constants and stage records.
// No dependencies.
package tpu_pkg;

  // Minimum words in a complete packet
  localparam int MIN_WORDS = 9;

  localparam logic [3:0] HEADER_NIB = 4'h8;
  localparam logic [3:0] FOOTER_NIB = 4'hE;

  localparam logic [15:0] IDX_MAX    = 16'hFFFF;
  localparam logic [15:0] IDX_HEADER = 16'd1;
  localparam logic [15:0] IDX_STAMP  = 16'd2;
  // Index of the final word at which the packet is complete
  localparam logic [15:0] IDX_FULL   = 16'(MIN_WORDS - 1);

  // End-of-packet record from the front stage
  typedef struct packed {
    logic        complete;
    logic        bad_header;
    logic        bad_footer;
    logic        count_mismatch;
    logic [27:0] count;
    logic [27:0] first_count;
    logic [31:0] stamp;
    logic [31:0] epoch;
    logic [31:0] first_stamp;
  } desc_t;

  // Record after the time and event arithmetic
  typedef struct packed {
    logic        complete;
    logic        bad_header;
    logic        bad_footer;
    logic        count_mismatch;
    logic [31:0] event_number;
    logic [63:0] time_ticks;
  } calc_t;

endpackage

// File: rtl/tpu_if.sv
// Stream interfaces of the trigger packet unpacker: packet words in, results out.
// No dependencies.
interface tpu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

interface tpu_out_if;
  logic        valid;
  logic        ready;
  logic        complete;
  logic        error;
  logic        bad_header;
  logic        bad_footer;
  logic        count_mismatch;
  logic [31:0] event_number;
  logic [63:0] time_ticks;
  logic [63:0] time_step_ticks;

  modport source (output valid, output complete, output error, output bad_header,
                  output bad_footer, output count_mismatch, output event_number,
                  output time_ticks, output time_step_ticks, input ready);
  modport sink   (input valid, input complete, input error, input bad_header,
                  input bad_footer, input count_mismatch, input event_number,
                  input time_ticks, input time_step_ticks, output ready);
endinterface

// File: rtl/tpu_front.sv
// Front stage: word counting, header/stamp capture, packet checks and run state.
// Depends on tpu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tpu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [31:0]    in_word,
  input  logic           in_last,
  output logic           in_ready,
  output logic           desc_valid,
  output tpu_pkg::desc_t desc,
  input  logic           desc_ready
);
  import tpu_pkg::*;

  logic [15:0] idx_r, idx_nxt;
  logic [31:0] header_r, stamp_r;
  logic        seen_r;
  logic [27:0] first_count_r;
  logic [31:0] first_stamp_r, last_stamp_r, epoch_r;
  logic        desc_v_r;
  desc_t       desc_r, desc_nxt;

  logic        acc, fin, full, fin_ok, wrap;
  logic [31:0] epoch_nxt;

  // Beat handshake: one end-of-packet record slot
  assign in_ready = !desc_v_r || desc_ready;
  assign acc      = in_valid && in_ready;
  assign fin      = acc && in_last;
  assign full     = idx_r >= IDX_FULL;
  assign fin_ok   = fin && full;

  // Saturating word index
  always_comb begin
    idx_nxt = idx_r;
    if (acc) begin
      if (in_last) begin
        idx_nxt = '0;
      end else if (idx_r != IDX_MAX) begin
        idx_nxt = idx_r + 16'd1;
      end
    end
  end

  // Timestamp wrap detection against the previous complete packet
  assign wrap      = stamp_r < last_stamp_r;
  assign epoch_nxt = epoch_r + {31'd0, wrap};

  // Checks on the final word; on short packets the check flags stay clear
  always_comb begin
    desc_nxt                = '0;
    desc_nxt.complete       = full;
    desc_nxt.count          = header_r[27:0];
    desc_nxt.first_count    = seen_r ? first_count_r : header_r[27:0];
    desc_nxt.stamp          = stamp_r;
    desc_nxt.epoch          = epoch_nxt;
    desc_nxt.first_stamp    = seen_r ? first_stamp_r : stamp_r;
    desc_nxt.bad_header     = full && (header_r[31:28] != HEADER_NIB);
    desc_nxt.bad_footer     = full && (in_word[31:28] != FOOTER_NIB);
    desc_nxt.count_mismatch = full && (header_r[27:0] != in_word[27:0]);
  end

  // Packet and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      header_r      <= '0;
      stamp_r       <= '0;
      seen_r        <= 1'b0;
      first_count_r <= '0;
      first_stamp_r <= '0;
      last_stamp_r  <= '0;
      epoch_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (acc && idx_r == IDX_HEADER) begin
        header_r <= in_word;
      end
      if (acc && idx_r == IDX_STAMP) begin
        stamp_r <= in_word;
      end
      if (fin_ok) begin
        epoch_r      <= epoch_nxt;
        last_stamp_r <= stamp_r;
        seen_r       <= 1'b1;
        if (!seen_r) begin
          first_count_r <= header_r[27:0];
          first_stamp_r <= stamp_r;
        end
      end
    end
  end

  // Record slot valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_v_r <= 1'b0;
    end else if (fin) begin
      desc_v_r <= 1'b1;
    end else if (desc_ready) begin
      desc_v_r <= 1'b0;
    end
  end

  // Record payload
  always_ff @(posedge clk) begin
    if (fin) begin
      desc_r <= desc_nxt;
    end
  end

  assign desc_valid = desc_v_r;
  assign desc       = desc_r;

  `TPU_ASSERT_NEXT(a_idx_clear, fin, idx_r == '0, "word index not cleared after final beat")
  `TPU_ASSERT_NEXT(a_desc_hold, desc_v_r && !desc_ready, desc_v_r && $stable(desc_r), "record lost while stalled")
  `TPU_ASSERT_NEXT(a_epoch_stable, !fin_ok, $stable(epoch_r) && $stable(last_stamp_r), "run state moved without a complete packet")

endmodule

// File: rtl/tpu_time.sv
// Time and event arithmetic and the result register.
// Depends on tpu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tpu_time (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           desc_valid,
  input  tpu_pkg::desc_t desc,
  output logic           desc_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_complete,
  output logic           out_error,
  output logic           out_bad_header,
  output logic           out_bad_footer,
  output logic           out_count_mismatch,
  output logic [31:0]    out_event_number,
  output logic [63:0]    out_time_ticks,
  output logic [63:0]    out_time_step_ticks
);
  import tpu_pkg::*;

  logic        calc_v_r, out_v_r;
  calc_t       calc_r, calc_nxt;
  logic        calc_ready, out_load;
  logic [63:0] prev_r;
  logic [63:0] step_nxt;

  logic        o_complete_r, o_bad_h_r, o_bad_f_r, o_mism_r;
  logic [31:0] o_event_r;
  logic [63:0] o_time_r, o_step_r;

  // Stage handshakes
  assign calc_ready = !out_v_r || out_ready;
  assign desc_ready = !calc_v_r || calc_ready;
  assign out_load   = calc_v_r && calc_ready;

  // Epoch-extended time and event number; short packets give zeros
  always_comb begin
    calc_nxt                = '0;
    calc_nxt.complete       = desc.complete;
    calc_nxt.bad_header     = desc.bad_header;
    calc_nxt.bad_footer     = desc.bad_footer;
    calc_nxt.count_mismatch = desc.count_mismatch;
    if (desc.complete) begin
      calc_nxt.event_number = {4'd0, desc.count} + 32'd1 - {4'd0, desc.first_count};
      calc_nxt.time_ticks   = {desc.epoch, desc.stamp} - {32'd0, desc.first_stamp};
    end
  end

  // Step from the previous complete packet (previous time is zero on the first)
  assign step_nxt = calc_r.time_ticks - (calc_r.complete ? prev_r : 64'd0);

  // Valid bits and previous time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      prev_r   <= '0;
    end else begin
      if (desc_valid && desc_ready) begin
        calc_v_r <= 1'b1;
      end else if (calc_ready) begin
        calc_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (out_load && calc_r.complete) begin
        prev_r <= calc_r.time_ticks;
      end
    end
  end

  // Arithmetic stage payload
  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      calc_r <= calc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_complete_r <= calc_r.complete;
      o_bad_h_r    <= calc_r.bad_header;
      o_bad_f_r    <= calc_r.bad_footer;
      o_mism_r     <= calc_r.count_mismatch;
      o_event_r    <= calc_r.event_number;
      o_time_r     <= calc_r.time_ticks;
      o_step_r     <= step_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_complete        = o_complete_r;
  assign out_error           = !o_complete_r || o_bad_h_r || o_bad_f_r || o_mism_r;
  assign out_bad_header      = o_bad_h_r;
  assign out_bad_footer      = o_bad_f_r;
  assign out_count_mismatch  = o_mism_r;
  assign out_event_number    = o_event_r;
  assign out_time_ticks      = o_time_r;
  assign out_time_step_ticks = o_step_r;

  `TPU_ASSERT_IMPL(a_short_zero, out_v_r && !o_complete_r, o_event_r == '0 && o_time_r == '0 && o_step_r == '0 && !o_bad_h_r, "short packet result not cleared")
  `TPU_ASSERT_NEXT(a_prev_track, out_load && calc_r.complete, prev_r == o_time_r, "previous time not taken from the result")
  `TPU_ASSERT_NEXT(a_out_hold, out_v_r && !out_ready, out_v_r && $stable(o_time_r) && $stable(o_event_r), "result changed while stalled")

endmodule

// File: rtl/trigger_packet_unpacker_top.sv
// Trigger packet unpacker, top level: front stage plus arithmetic/result stages.
// Depends on tpu_pkg, tpu_if, tpu_front, tpu_time.
//
// Takes one 32-bit packet word per beat on in_bus and delivers one result
// beat on out_bus per packet, after the beat flagged last. Every word can be
// accepted on consecutive cycles while the front record slot is free; the
// result passes the front record, arithmetic stage and result register in
// order and, once registered, can be taken at the following edge. The path
// is limited by the two 64-bit subtractions for time and time step, which sit
// in separate stages. Packets shorter than the minimum length report an error
// with zeroed fields and leave the event, stamp and epoch state untouched.
module trigger_packet_unpacker_top (
  input  logic      clk,
  input  logic      rst_n,
  tpu_in_if.sink    in_bus,
  tpu_out_if.source out_bus
);
  import tpu_pkg::*;

  logic  desc_valid, desc_ready;
  desc_t desc;

  tpu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_word    (in_bus.word),
    .in_last    (in_bus.last),
    .in_ready   (in_bus.ready),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready)
  );

  tpu_time u_time (
    .clk                 (clk),
    .rst_n               (rst_n),
    .desc_valid          (desc_valid),
    .desc                (desc),
    .desc_ready          (desc_ready),
    .out_valid           (out_bus.valid),
    .out_ready           (out_bus.ready),
    .out_complete        (out_bus.complete),
    .out_error           (out_bus.error),
    .out_bad_header      (out_bus.bad_header),
    .out_bad_footer      (out_bus.bad_footer),
    .out_count_mismatch  (out_bus.count_mismatch),
    .out_event_number    (out_bus.event_number),
    .out_time_ticks      (out_bus.time_ticks),
    .out_time_step_ticks (out_bus.time_step_ticks)
  );

endmodule

// File: tb/sv/trigger_packet_unpacker_top_test.sv
// Self-checking test of trigger_packet_unpacker_top: packet words in, one checked result per packet.
// Depends on tpu_pkg and tpu_if from the RTL; the tracker class lives in tpu_test_pkg below.
// Stimulus: directed corner packets, then random packets under several idle/stall mixes.
package tpu_test_pkg;
  import tpu_pkg::*;

  typedef struct packed {
    logic        complete;
    logic        error;
    logic        bad_header;
    logic        bad_footer;
    logic        count_mismatch;
    logic [31:0] event_number;
    logic [63:0] time_ticks;
    logic [63:0] time_step_ticks;
  } event_result_t;

  // Tracks the unpacker state per accepted beat and holds the results still owed
  class unpacked_event_tracker;
    bit [15:0]     word_count;
    bit [31:0]     header_word;
    bit [31:0]     stamp_word;
    bit            seen_first;
    bit [27:0]     first_count;
    bit [31:0]     first_stamp;
    bit [31:0]     last_stamp;
    bit [31:0]     wrap_epoch;
    bit [63:0]     previous_time;
    event_result_t pending_events[$];
    int            mismatch_count;
    int            results_seen;

    function int pending();
      return pending_events.size();
    endfunction

    // Append one owed result at the tail
    function void queue_result(input event_result_t r);
      pending_events = {pending_events, r};
    endfunction

    task flag_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("ERROR: result %0d field %s got 0x%0h expected 0x%0h",
               results_seen, field, got, want);
      mismatch_count++;
    endtask

    // Advance the packet state by one accepted beat; queue a result on the last beat
    function void take_word(input logic [31:0] w, input logic fin);
      bit [15:0]     idx;
      bit [27:0]     cnt;
      bit [63:0]     ticks;
      event_result_t r;
      idx = word_count;
      if (idx == IDX_HEADER) header_word = w;
      else if (idx == IDX_STAMP) stamp_word = w;
      if (!fin) begin
        if (word_count != IDX_MAX) word_count++;
        return;
      end
      word_count = '0;
      r = '0;
      // too short: error only, no state touched
      if (int'(idx) + 1 < MIN_WORDS) begin
        r.error = 1'b1;
        queue_result(r);
        return;
      end
      cnt              = header_word[27:0];
      r.complete       = 1'b1;
      r.bad_header     = header_word[31:28] != HEADER_NIB;
      r.bad_footer     = w[31:28] != FOOTER_NIB;
      r.count_mismatch = cnt != w[27:0];
      r.error          = r.bad_header | r.bad_footer | r.count_mismatch;
      if (!seen_first) first_count = cnt;
      // stamp going backwards means the 32-bit counter wrapped
      if (stamp_word < last_stamp) wrap_epoch++;
      last_stamp = stamp_word;
      if (!seen_first) begin
        first_stamp   = stamp_word;
        previous_time = '0;
      end
      ticks             = {wrap_epoch, stamp_word} - {32'd0, first_stamp};
      r.event_number    = {4'd0, cnt} + 32'd1 - {4'd0, first_count};
      r.time_ticks      = ticks;
      r.time_step_ticks = ticks - previous_time;
      previous_time     = ticks;
      seen_first        = 1'b1;
      queue_result(r);
    endfunction

    // Compare one delivered result with the oldest one owed
    task compare_event(input event_result_t got);
      event_result_t want;
      results_seen++;
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected", 64'(got.event_number), 64'd0);
        return;
      end
      want = pending_events.pop_front();
      if (got.complete !== want.complete)
        flag_mismatch("complete", 64'(got.complete), 64'(want.complete));
      if (got.error !== want.error)
        flag_mismatch("error", 64'(got.error), 64'(want.error));
      if (got.bad_header !== want.bad_header)
        flag_mismatch("bad_header", 64'(got.bad_header), 64'(want.bad_header));
      if (got.bad_footer !== want.bad_footer)
        flag_mismatch("bad_footer", 64'(got.bad_footer), 64'(want.bad_footer));
      if (got.count_mismatch !== want.count_mismatch)
        flag_mismatch("count_mismatch", 64'(got.count_mismatch), 64'(want.count_mismatch));
      if (got.event_number !== want.event_number)
        flag_mismatch("event_number", 64'(got.event_number), 64'(want.event_number));
      if (got.time_ticks !== want.time_ticks)
        flag_mismatch("time_ticks", got.time_ticks, want.time_ticks);
      if (got.time_step_ticks !== want.time_step_ticks)
        flag_mismatch("time_step_ticks", got.time_step_ticks, want.time_step_ticks);
    endtask
  endclass
endpackage

module trigger_packet_unpacker_top_test;
  import tpu_pkg::*;
  import tpu_test_pkg::*;

  localparam int STUCK_LIMIT  = 3000;
  localparam int SETTLE_WAIT  = 8;
  localparam int PHASE_WORDS  = 195;
  localparam int NUM_PHASES   = 5;
  localparam int HOLD_CYCLES  = 400;
  localparam int LONG_WORDS   = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tpu_in_if  in_bus ();
  tpu_out_if out_bus ();

  trigger_packet_unpacker_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  unpacked_event_tracker tracker;
  event_result_t         seen_result;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    hold_request;
  int                    hold_left;
  int                    stuck_cycles;
  int                    words_sent;
  logic [27:0]           trig_count;
  logic [31:0]           cur_stamp;

  always #5 clk = ~clk;

  initial begin
    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    stuck_cycles   = 0;
    words_sent     = 0;
    in_bus.valid   = 1'b0;
    in_bus.word    = '0;
    in_bus.last    = 1'b0;
    out_bus.ready  = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Beat monitors and watchdog
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      tracker.take_word(in_bus.word, in_bus.last);
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_result.complete        = out_bus.complete;
      seen_result.error           = out_bus.error;
      seen_result.bad_header      = out_bus.bad_header;
      seen_result.bad_footer      = out_bus.bad_footer;
      seen_result.count_mismatch  = out_bus.count_mismatch;
      seen_result.event_number    = out_bus.event_number;
      seen_result.time_ticks      = out_bus.time_ticks;
      seen_result.time_step_ticks = out_bus.time_step_ticks;
      tracker.compare_event(seen_result);
    end
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One beat; called and returns at a falling edge, valid left high for back-to-back beats
  task automatic send_word(input logic [31:0] w, input logic fin);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.word  <= w;
    in_bus.last  <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Word 1 header, word 2 stamp, final word footer; the footer wins on short packets
  task automatic send_packet(input int len, input logic [31:0] hdr, input logic [31:0] stamp,
                             input logic [31:0] ftr, input bit zero_fill);
    logic [31:0] w;
    int          i;
    for (i = 0; i < len; i++) begin
      if (i == len - 1) w = ftr;
      else if (i == 1) w = hdr;
      else if (i == 2) w = stamp;
      else w = zero_fill ? 32'd0 : 32'($urandom);
      send_word(w, i == len - 1);
    end
  endtask

  // Stop offering, let every owed result drain, then wait out the settle time
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // Mostly well-formed packets, some corrupted, short or pure noise
  task automatic send_random_packet();
    int          kind;
    int          pick;
    int          len;
    logic [31:0] hdr;
    logic [31:0] ftr;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (pick < 70) cur_stamp = cur_stamp + 32'($urandom_range(1, 200000));
    else if (pick < 90) cur_stamp = $urandom;
    else if (pick < 95) cur_stamp = cur_stamp - 32'($urandom_range(1, 1000));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                      : $urandom_range(MIN_WORDS, MIN_WORDS + 7);
    hdr = {HEADER_NIB, trig_count};
    ftr = {FOOTER_NIB, trig_count};
    trig_count++;
    if (kind >= 90) begin
      len       = $urandom_range(1, 20);
      hdr       = $urandom;
      ftr       = $urandom;
      cur_stamp = $urandom;
    end else if (kind >= 80) begin
      len = $urandom_range(1, MIN_WORDS - 1);
    end else if (kind >= 70) begin
      case ($urandom_range(0, 3))
        0: hdr[31:28] = HEADER_NIB ^ 4'($urandom_range(1, 15));
        1: ftr[31:28] = FOOTER_NIB ^ 4'($urandom_range(1, 15));
        2: ftr[27:0]  = ftr[27:0] ^ (28'd1 << $urandom_range(0, 27));
        default: trig_count = trig_count + 28'($urandom);
      endcase
    end
    send_packet(len, hdr, cur_stamp, ftr, 1'b0);
  endtask

  initial begin
    int phase;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: short packets before any complete one
    send_packet(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_packet(MIN_WORDS - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // first complete packet carries every error; its count and stamp still anchor
    send_packet(MIN_WORDS, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0000, 1'b0);
    // count wraps to zero, stamp goes backwards
    send_packet(MIN_WORDS, {HEADER_NIB, 28'd0}, 32'h0000_0005, {FOOTER_NIB, 28'd0}, 1'b0);
    // long packet: zero words between the stamp and the footer
    send_packet(LONG_WORDS, {HEADER_NIB, 28'd1}, 32'h0000_0010, {FOOTER_NIB, 28'd1}, 1'b1);
    // short packets after the first must leave the time base alone
    send_packet(2, {HEADER_NIB, 28'd7}, 32'h0, {FOOTER_NIB, 28'd7}, 1'b0);
    send_packet(3, {HEADER_NIB, 28'd7}, 32'h0, {FOOTER_NIB, 28'd7}, 1'b0);
    // same stamp as before: no wrap, zero step
    send_packet(MIN_WORDS, {HEADER_NIB, 28'd2}, 32'h0000_0010, {FOOTER_NIB, 28'd2}, 1'b0);
    wait_drained();

    // Random packets under each idle/stall mix
    trig_count = 28'd3;
    cur_stamp  = 32'h0000_0010;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // back pressure: results held off while packets keep coming
      if (phase == 0) hold_request = HOLD_CYCLES;
      words_sent = 0;
      while (words_sent < PHASE_WORDS) send_random_packet();
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_WAIT) @(negedge clk);
    if (tracker.pending() != 0)
      tracker.flag_mismatch("leftover", 64'(tracker.pending()), 64'd0);
    if (tracker.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
